FILE: design/eqst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package eqst_pkg;

    // Field widths of the command and result words.
    localparam int ACTION_W     = 3;
    localparam int ID_BITS      = 16;
    localparam int TYPE_W       = 8;
    localparam int PAYLOAD_BITS = 32;
    localparam int EVENTS_W     = 32;
    localparam int PENDING_W    = 7;

    // Default sizes of the source table and the event ring.
    localparam int DEF_SOURCE_SLOTS = 8;
    localparam int DEF_QUEUE_DEPTH  = 64;

    // Command codes.
    localparam logic [ACTION_W-1:0] ACT_REGISTER   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_UNREGISTER = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_INFO       = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_EMIT       = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ       = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_SHUTDOWN   = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_INIT       = 3'd6;

    // Command word.
    typedef struct packed {
        logic [ACTION_W-1:0]     action;
        logic [ID_BITS-1:0]      source_id;
        logic [TYPE_W-1:0]       source_type;
        logic [PAYLOAD_BITS-1:0] event_payload;
    } t_cmd;

    // Result word.
    typedef struct packed {
        logic                    status;
        logic [ID_BITS-1:0]      assigned_id;
        logic [TYPE_W-1:0]       info_type;
        logic [EVENTS_W-1:0]     info_events;
        logic [ID_BITS-1:0]      read_source;
        logic [PAYLOAD_BITS-1:0] read_payload;
        logic [PENDING_W-1:0]    pending;
    } t_result;

    // One queued event as stored in the ring memory.
    typedef struct packed {
        logic [ID_BITS-1:0]      source;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_event;

    // One source slot as stored in the slot memory.
    typedef struct packed {
        logic [TYPE_W-1:0]   slot_type;
        logic [EVENTS_W-1:0] events;
    } t_slot_word;

    // Updates to the source table.
    typedef struct packed {
        logic alloc;
        logic release_slot;
        logic clear;
        logic restart;
    } t_tbl_ctl;

    // Updates to the event ring.
    typedef struct packed {
        logic push;
        logic pop;
        logic flush;
        logic restart;
    } t_ring_ctl;

endpackage
`default_nettype wire

FILE: design/eqst_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module eqst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: design/eqst_table.sv
`timescale 1ns / 1ps
`default_nettype none
module eqst_table #(
    parameter int SOURCE_SLOTS = eqst_pkg::DEF_SOURCE_SLOTS,
    localparam int SLOT_AW = (SOURCE_SLOTS > 1) ? $clog2(SOURCE_SLOTS) : 1
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire eqst_pkg::t_tbl_ctl           i_ctl,
    input  wire logic [eqst_pkg::ID_BITS-1:0] i_lookup_id,
    output logic                              o_hit,
    output logic      [SLOT_AW-1:0]           o_hit_slot,
    output logic                              o_has_free,
    output logic      [SLOT_AW-1:0]           o_free_slot,
    output logic      [eqst_pkg::ID_BITS-1:0] o_next_id
);

    import eqst_pkg::*;

    logic [SOURCE_SLOTS-1:0] r_active;
    logic [ID_BITS-1:0]      r_slot_id [SOURCE_SLOTS];
    logic [ID_BITS-1:0]      r_next_id;

    // Parallel compare over all slots; the lowest matching slot wins.
    always_comb begin
        o_hit       = 1'b0;
        o_hit_slot  = '0;
        o_has_free  = 1'b0;
        o_free_slot = '0;
        for (int i = SOURCE_SLOTS - 1; i >= 0; i--) begin
            if (r_active[i] && (r_slot_id[i] == i_lookup_id)) begin
                o_hit      = 1'b1;
                o_hit_slot = SLOT_AW'(i);
            end
            if (!r_active[i]) begin
                o_has_free  = 1'b1;
                o_free_slot = SLOT_AW'(i);
            end
        end
    end

    assign o_next_id = r_next_id;

    // Active flags and the id counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.restart) begin
            r_active  <= '0;
            r_next_id <= ID_BITS'(1);
        end else if (i_ctl.clear) begin
            r_active <= '0;
        end else if (i_ctl.alloc) begin
            r_active[o_free_slot] <= 1'b1;
            r_next_id             <= r_next_id + ID_BITS'(1);
        end else if (i_ctl.release_slot) begin
            r_active[o_hit_slot] <= 1'b0;
        end
    end

    // Slot ids are kept in flops so that all of them can be compared at once.
    always_ff @(posedge i_clk) begin
        if (i_ctl.alloc) begin
            r_slot_id[o_free_slot] <= r_next_id;
        end
    end

endmodule
`default_nettype wire

FILE: design/eqst_ring.sv
`timescale 1ns / 1ps
`default_nettype none
module eqst_ring #(
    parameter int QUEUE_DEPTH = eqst_pkg::DEF_QUEUE_DEPTH,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire eqst_pkg::t_ring_ctl i_ctl,
    input  wire eqst_pkg::t_event    i_entry,
    output eqst_pkg::t_event         o_head_entry,
    output logic                     o_full,
    output logic                     o_empty,
    output logic      [CNT_W-1:0]    o_count
);

    import eqst_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] r_tail;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_head;
    logic [PTR_W-1:0] n_tail;

    // Pointers wrap at the ring depth, which need not be a power of two.
    assign n_head = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + PTR_W'(1);
    assign n_tail = (r_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + PTR_W'(1);

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

    // Pointer and fill count bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.restart) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_ctl.flush) begin
            r_count <= '0;
        end else if (i_ctl.push) begin
            r_tail  <= n_tail;
            r_count <= r_count + CNT_W'(1);
        end else if (i_ctl.pop) begin
            r_head  <= n_head;
            r_count <= r_count - CNT_W'(1);
        end
    end

    // Event storage; the head entry is read every cycle and shows up on the next cycle.
    eqst_ram #(
        .WIDTH ($bits(t_event)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.push),
        .i_waddr (r_tail),
        .i_wdata (i_entry),
        .i_raddr (r_head),
        .o_rdata (o_head_entry)
    );

endmodule
`default_nettype wire

FILE: design/event_queue_with_source_table_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Handshake          | Word     | Direction
// ---------+--------------------+----------+----------
// command  | start / busy       | i_cmd    | in
// result   | o_done (strobe)    | o_result | out
//
// A command word is taken when start is high and busy is low.
// Each command passes through capture, table lookup with memory access,
// and result; the slot memory read-modify-write and the ring memory read set these steps.
// Exactly one result word follows each command, on o_done for one cycle;
// the receiver cannot stall it. busy is high from capture until the result cycle ends.
// Synchronous active-low reset empties the table and the ring and marks the block ready.
module event_queue_with_source_table_core #(
    parameter int SOURCE_SLOTS = eqst_pkg::DEF_SOURCE_SLOTS,
    parameter int QUEUE_DEPTH  = eqst_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire eqst_pkg::t_cmd i_cmd,
    output logic                o_done,
    output eqst_pkg::t_result   o_result
);

    import eqst_pkg::*;

    localparam int SLOT_AW = (SOURCE_SLOTS > 1) ? $clog2(SOURCE_SLOTS) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    t_cmd               r_cmd;
    logic               r_ready;
    logic               r_ok;
    logic               n_ok;
    logic [ID_BITS-1:0] r_assigned;
    logic [SLOT_AW-1:0] r_slot;

    t_tbl_ctl           tbl_ctl;
    logic               tbl_hit;
    logic [SLOT_AW-1:0] tbl_hit_slot;
    logic               tbl_has_free;
    logic [SLOT_AW-1:0] tbl_free_slot;
    logic [ID_BITS-1:0] tbl_next_id;

    t_ring_ctl          ring_ctl;
    t_event             ring_wr;
    t_event             ring_head;
    logic               ring_full;
    logic               ring_empty;
    logic [CNT_W-1:0]   ring_count;

    logic               slot_we;
    logic [SLOT_AW-1:0] slot_waddr;
    t_slot_word         slot_wdata;
    t_slot_word         slot_rdata;

    // Sequencer: capture, lookup, result.
    always_comb begin
        case (r_state)
            S_IDLE:  n_state = start ? S_LOOK : S_IDLE;
            S_LOOK:  n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

    // Command capture.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_cmd <= i_cmd;
        end
    end

    // Decide the command outcome in the lookup cycle and drive the updates.
    always_comb begin
        n_ok     = 1'b0;
        tbl_ctl  = '0;
        ring_ctl = '0;
        if (r_state == S_LOOK) begin
            case (r_cmd.action)
                ACT_REGISTER: begin
                    n_ok          = r_ready && tbl_has_free;
                    tbl_ctl.alloc = n_ok;
                end
                ACT_UNREGISTER: begin
                    n_ok                 = tbl_hit;
                    tbl_ctl.release_slot = n_ok;
                end
                ACT_INFO: begin
                    n_ok = tbl_hit;
                end
                ACT_EMIT: begin
                    n_ok          = r_ready && tbl_hit && !ring_full;
                    ring_ctl.push = n_ok;
                end
                ACT_READ: begin
                    n_ok         = !ring_empty;
                    ring_ctl.pop = n_ok;
                end
                ACT_SHUTDOWN: begin
                    n_ok           = 1'b1;
                    tbl_ctl.clear  = 1'b1;
                    ring_ctl.flush = 1'b1;
                end
                ACT_INIT: begin
                    n_ok             = 1'b1;
                    tbl_ctl.restart  = 1'b1;
                    ring_ctl.restart = 1'b1;
                end
                default: begin
                    n_ok = 1'b0;
                end
            endcase
        end
    end

    // Ready flag: cleared by shutdown, set again by init.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || tbl_ctl.restart) begin
            r_ready <= 1'b1;
        end else if (tbl_ctl.clear) begin
            r_ready <= 1'b0;
        end
    end

    // Outcome kept for the result cycle.
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOOK) begin
            r_ok       <= n_ok;
            r_assigned <= tbl_next_id;
            r_slot     <= tbl_hit_slot;
        end
    end

    // Slot memory writes: a new slot starts at zero events, an emit adds one.
    always_comb begin
        slot_we    = 1'b0;
        slot_waddr = tbl_free_slot;
        slot_wdata = '{slot_type: r_cmd.source_type, events: '0};
        if (tbl_ctl.alloc) begin
            slot_we = 1'b1;
        end else if (r_state == S_DONE && r_ok && r_cmd.action == ACT_EMIT) begin
            slot_we    = 1'b1;
            slot_waddr = r_slot;
            slot_wdata = '{slot_type: slot_rdata.slot_type,
                           events: slot_rdata.events + EVENTS_W'(1)};
        end
    end

    assign ring_wr = '{source: r_cmd.source_id, payload: r_cmd.event_payload};

    eqst_table #(
        .SOURCE_SLOTS (SOURCE_SLOTS)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (tbl_ctl),
        .i_lookup_id (r_cmd.source_id),
        .o_hit       (tbl_hit),
        .o_hit_slot  (tbl_hit_slot),
        .o_has_free  (tbl_has_free),
        .o_free_slot (tbl_free_slot),
        .o_next_id   (tbl_next_id)
    );

    eqst_ram #(
        .WIDTH ($bits(t_slot_word)),
        .DEPTH (SOURCE_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (tbl_hit_slot),
        .o_rdata (slot_rdata)
    );

    eqst_ring #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ring_ctl),
        .i_entry      (ring_wr),
        .o_head_entry (ring_head),
        .o_full       (ring_full),
        .o_empty      (ring_empty),
        .o_count      (ring_count)
    );

    // Result word; fields that do not belong to the command read as zero.
    always_comb begin
        o_result        = '0;
        o_result.status = !r_ok;
        o_result.pending = PENDING_W'(ring_count);
        if (r_ok) begin
            case (r_cmd.action)
                ACT_REGISTER: begin
                    o_result.assigned_id = r_assigned;
                end
                ACT_INFO: begin
                    o_result.info_type   = slot_rdata.slot_type;
                    o_result.info_events = slot_rdata.events;
                end
                ACT_READ: begin
                    o_result.read_source  = ring_head.source;
                    o_result.read_payload = ring_head.payload;
                end
                default: begin
                    o_result.assigned_id = '0;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: tb/eqst_checker.sv
`timescale 1ns / 1ps
module eqst_checker
    import eqst_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_busy,
    input  t_cmd    i_cmd,
    input  logic    i_done,
    input  t_result i_result,
    output int      o_errors,
    output int      o_waiting
);

    localparam int SLOTS = DEF_SOURCE_SLOTS;
    localparam int DEPTH = DEF_QUEUE_DEPTH;

    // Shadow copy of the source table.
    logic                    src_active [SLOTS];
    logic [ID_BITS-1:0]      src_id     [SLOTS];
    logic [TYPE_W-1:0]       src_type   [SLOTS];
    logic [EVENTS_W-1:0]     src_count  [SLOTS];
    logic [ID_BITS-1:0]      id_next;

    // Shadow copy of the event ring.
    logic [ID_BITS-1:0]      evq_source  [DEPTH];
    logic [PAYLOAD_BITS-1:0] evq_payload [DEPTH];
    int                      rd_ptr;
    int                      wr_ptr;
    logic [PENDING_W-1:0]    evq_fill;
    logic                    accepting;

    // Result words predicted for commands that have been taken.
    t_result                 expected_results [$];
    int                      errors = 0;

    function automatic void restore_defaults();
        for (int k = 0; k < SLOTS; k++) begin
            src_active[k] = 1'b0;
        end
        id_next   = ID_BITS'(1);
        rd_ptr    = 0;
        wr_ptr    = 0;
        evq_fill  = '0;
        accepting = 1'b1;
    endfunction

    // Lowest active slot holding the id, or -1.
    function automatic int find_source(logic [ID_BITS-1:0] id);
        for (int k = 0; k < SLOTS; k++) begin
            if (src_active[k] && src_id[k] == id) begin
                return k;
            end
        end
        return -1;
    endfunction

    // Applies one command to the shadow state and returns its result word.
    function automatic t_result predict_result(t_cmd c);
        t_result r;
        int      s;
        r        = '0;
        r.status = 1'b1;
        case (c.action)
            ACT_REGISTER: begin
                if (accepting) begin
                    s = -1;
                    for (int k = 0; k < SLOTS; k++) begin
                        if (s < 0 && !src_active[k]) begin
                            s = k;
                        end
                    end
                    if (s >= 0) begin
                        src_active[s]  = 1'b1;
                        src_id[s]      = id_next;
                        src_type[s]    = c.source_type;
                        src_count[s]   = '0;
                        r.status       = 1'b0;
                        r.assigned_id  = id_next;
                        id_next        = id_next + 1'b1;
                    end
                end
            end
            ACT_UNREGISTER: begin
                s = find_source(c.source_id);
                if (s >= 0) begin
                    src_active[s] = 1'b0;
                    r.status      = 1'b0;
                end
            end
            ACT_INFO: begin
                s = find_source(c.source_id);
                if (s >= 0) begin
                    r.status      = 1'b0;
                    r.info_type   = src_type[s];
                    r.info_events = src_count[s];
                end
            end
            ACT_EMIT: begin
                s = find_source(c.source_id);
                if (accepting && s >= 0 && evq_fill < DEPTH) begin
                    evq_source[wr_ptr]  = c.source_id;
                    evq_payload[wr_ptr] = c.event_payload;
                    wr_ptr              = (wr_ptr + 1) % DEPTH;
                    evq_fill            = evq_fill + 1'b1;
                    src_count[s]        = src_count[s] + 1'b1;
                    r.status            = 1'b0;
                end
            end
            ACT_READ: begin
                if (evq_fill != 0) begin
                    r.read_source  = evq_source[rd_ptr];
                    r.read_payload = evq_payload[rd_ptr];
                    rd_ptr         = (rd_ptr + 1) % DEPTH;
                    evq_fill       = evq_fill - 1'b1;
                    r.status       = 1'b0;
                end
            end
            ACT_SHUTDOWN: begin
                // Pointers stay where they are; only the count is dropped.
                for (int k = 0; k < SLOTS; k++) begin
                    src_active[k] = 1'b0;
                end
                evq_fill  = '0;
                accepting = 1'b0;
                r.status  = 1'b0;
            end
            ACT_INIT: begin
                restore_defaults();
                r.status = 1'b0;
            end
            default: begin
            end
        endcase
        r.pending = evq_fill;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Compare each result word with the oldest prediction, then log new commands.
    always @(posedge i_clk) begin : score
        t_result want;
        if (!i_rst_n) begin
            restore_defaults();
            expected_results.delete();
        end else begin
            if (i_done) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result word with no command waiting, expected none, actual %h",
                             $time, i_result);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(want.status), 32'(i_result.status));
                    check_field("assigned_id", 32'(want.assigned_id),
                                32'(i_result.assigned_id));
                    check_field("info_type", 32'(want.info_type), 32'(i_result.info_type));
                    check_field("info_events", want.info_events, i_result.info_events);
                    check_field("read_source", 32'(want.read_source),
                                32'(i_result.read_source));
                    check_field("read_payload", want.read_payload, i_result.read_payload);
                    check_field("pending", 32'(want.pending), 32'(i_result.pending));
                end
            end
            if (i_start && !i_busy) begin
                expected_results.push_back(predict_result(i_cmd));
            end
        end
        o_errors  <= errors;
        o_waiting <= expected_results.size();
    end

endmodule

FILE: tb/event_queue_with_source_table_core_tb.sv
`timescale 1ns / 1ps
module event_queue_with_source_table_core_tb;
    import eqst_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int RANDOM_ITEMS   = 900;
    localparam int POOL_MAX       = 12;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start   = 1'b0;
    t_cmd                i_cmd   = '0;
    logic                busy;
    logic                o_done;
    t_result             o_result;
    int                  errors;
    int                  waiting;

    int                  quiet_cycles = 0;
    bit                  no_idle      = 1'b0;
    logic [ACTION_W-1:0] sent_action  = ACT_UNUSED;
    logic [ID_BITS-1:0]  sent_id      = '0;
    logic [ID_BITS-1:0]  id_pool [$];

    event_queue_with_source_table_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result)
    );

    eqst_checker u_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_busy   (busy),
        .i_cmd    (i_cmd),
        .i_done   (o_done),
        .i_result (o_result),
        .o_errors (errors),
        .o_waiting(waiting)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Count cycles in which no word moves on either channel.
    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Keep a pool of live source ids so that most commands name a real source.
    always @(posedge i_clk) begin : track_ids
        int k;
        if (o_done) begin
            case (sent_action)
                ACT_REGISTER: begin
                    if (!o_result.status) begin
                        id_pool.push_back(o_result.assigned_id);
                        if (id_pool.size() > POOL_MAX) begin
                            id_pool.pop_front();
                        end
                    end
                end
                ACT_UNREGISTER: begin
                    if (!o_result.status) begin
                        for (k = 0; k < id_pool.size(); k++) begin
                            if (id_pool[k] == sent_id) begin
                                id_pool.delete(k);
                                break;
                            end
                        end
                    end
                end
                ACT_SHUTDOWN, ACT_INIT: begin
                    id_pool.delete();
                end
                default: begin
                end
            endcase
        end
        // Remember the command just taken until its result word comes back.
        if (i_rst_n && start && !busy) begin
            sent_action = i_cmd.action;
            sent_id     = i_cmd.source_id;
        end
    end

    function automatic t_cmd make_cmd(logic [ACTION_W-1:0] act, logic [ID_BITS-1:0] id,
                                      logic [TYPE_W-1:0] typ, logic [PAYLOAD_BITS-1:0] data);
        t_cmd c;
        c.action        = act;
        c.source_id     = id;
        c.source_type   = typ;
        c.event_payload = data;
        return c;
    endfunction

    function automatic logic [ID_BITS-1:0] pick_id();
        if (id_pool.size() > 0 && $urandom_range(0, 9) < 8) begin
            return id_pool[$urandom_range(0, id_pool.size() - 1)];
        end
        return ID_BITS'($urandom);
    endfunction

    // Send one command word: idle for a random gap unless no_idle is set, then hold start until taken.
    task automatic send_word(input t_cmd c);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int                  k;
        int                  n;
        int                  mode;
        int                  roll;
        int                  t_reg;
        int                  t_unreg;
        int                  t_info;
        int                  t_emit;
        int                  t_read;
        bit                  down;
        logic [ACTION_W-1:0] act;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: empty read, extreme fields, unknown ids, full table,
        // shutdown refusals and init.
        send_word(make_cmd(ACT_READ, '0, '0, '0));
        send_word(make_cmd(ACT_REGISTER, '0, 8'h00, '0));
        send_word(make_cmd(ACT_REGISTER, '1, 8'hFF, '1));
        send_word(make_cmd(ACT_INFO, 16'd1, '0, '0));
        send_word(make_cmd(ACT_INFO, 16'hFFFF, '1, '1));
        send_word(make_cmd(ACT_EMIT, 16'd1, '0, 32'h0000_0000));
        send_word(make_cmd(ACT_EMIT, 16'd2, '1, 32'hFFFF_FFFF));
        send_word(make_cmd(ACT_EMIT, 16'd0, '0, 32'h1234_5678));
        send_word(make_cmd(ACT_INFO, 16'd2, '0, '0));
        send_word(make_cmd(ACT_READ, '1, '1, '1));
        send_word(make_cmd(ACT_UNREGISTER, 16'd1, '0, '0));
        send_word(make_cmd(ACT_UNUSED, ID_BITS'($urandom), TYPE_W'($urandom), $urandom));
        for (k = 0; k < 8; k++) begin
            send_word(make_cmd(ACT_REGISTER, ID_BITS'($urandom), TYPE_W'($urandom), $urandom));
        end
        send_word(make_cmd(ACT_SHUTDOWN, '0, '0, '0));
        send_word(make_cmd(ACT_REGISTER, '0, 8'h5A, '0));
        send_word(make_cmd(ACT_EMIT, 16'd2, '0, 32'hA5A5_A5A5));
        send_word(make_cmd(ACT_READ, '0, '0, '0));
        send_word(make_cmd(ACT_INIT, '0, '0, '0));

        // Register six sources back to back with no idling, then follow one id
        // through info, emit and unregister.
        no_idle = 1'b1;
        for (k = 0; k < 6; k++) begin
            send_word(make_cmd(ACT_REGISTER, ID_BITS'($urandom), TYPE_W'($urandom), $urandom));
        end
        send_word(make_cmd(ACT_INFO, 16'd1, '0, '0));
        send_word(make_cmd(ACT_EMIT, 16'd1, '0, $urandom));
        send_word(make_cmd(ACT_UNREGISTER, 16'd1, '0, '0));
        send_word(make_cmd(ACT_INFO, 16'd1, '0, '0));
        send_word(make_cmd(ACT_EMIT, 16'd1, '0, $urandom));
        send_word(make_cmd(ACT_READ, '0, '0, '0));
        send_word(make_cmd(ACT_READ, '0, '0, '0));
        no_idle = 1'b0;

        // Random traffic in phases that fill the ring, drain it, or mix freely.
        down = 1'b0;
        mode = 2;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                mode    = $urandom_range(0, 2);
                no_idle = ($urandom_range(0, 3) == 0);
            end
            case (mode)
                0: begin
                    t_reg = 10; t_unreg = 15; t_info = 25; t_emit = 85; t_read = 95;
                end
                1: begin
                    t_reg = 10; t_unreg = 20; t_info = 30; t_emit = 45; t_read = 95;
                end
                default: begin
                    t_reg = 20; t_unreg = 32; t_info = 47; t_emit = 72; t_read = 92;
                end
            endcase
            roll = $urandom_range(0, 99);
            if (down && roll < 40) begin
                act = ACT_INIT;
            end else if (roll < t_reg) begin
                act = ACT_REGISTER;
            end else if (roll < t_unreg) begin
                act = ACT_UNREGISTER;
            end else if (roll < t_info) begin
                act = ACT_INFO;
            end else if (roll < t_emit) begin
                act = ACT_EMIT;
            end else if (roll < t_read) begin
                act = ACT_READ;
            end else begin
                case ($urandom_range(0, 2))
                    0:       act = ACT_SHUTDOWN;
                    1:       act = ACT_INIT;
                    default: act = ACT_UNUSED;
                endcase
            end
            if (act == ACT_SHUTDOWN) begin
                down = 1'b1;
            end else if (act == ACT_INIT) begin
                down = 1'b0;
            end
            send_word(make_cmd(act, pick_id(), TYPE_W'($urandom), $urandom));
        end
        start <= 1'b0;

        // Wait for the last result word, then let the block settle.
        do @(posedge i_clk); while (waiting != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0 && waiting == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/eqst_pkg.sv
design/eqst_ram.sv
design/eqst_table.sv
design/eqst_ring.sv
design/event_queue_with_source_table_core.sv
tb/eqst_checker.sv
tb/event_queue_with_source_table_core_tb.sv
